// ----- rtl/core/kps_pkg.sv -----
// kps_pkg: shared sizes, codes and types of the key / ptt sequencer
// no dependencies; imported by every module of the block

package kps_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;
   localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int CHAN_W  = 5;
   localparam int NOTE_W  = 7;
   localparam int DELAY_W = 16;
   localparam int HANG_W  = 20;
   localparam int CNT_W   = HANG_W + 1;
   localparam int CSR_W   = 20;

   localparam logic [7:0] CMD_MASK  = 8'hF0;
   localparam logic [7:0] CMD_ON    = 8'h90;
   localparam logic [7:0] CMD_OFF   = 8'h80;
   localparam logic [3:0] CHAN_MASK = 4'hF;

   typedef enum logic [1:0] {
      REG_MIDI_CHANNEL  = 2'd0,
      REG_KEY_NOTE      = 2'd1,
      REG_DELAY_SAMPLES = 2'd2,
      REG_HANG_SAMPLES  = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_ON   = 2'd1,
      EV_OFF  = 2'd2
   } evt_type;

   // decoded key transition of one word
   typedef struct packed {
      logic hit;
      logic is_on;
   } key_cmd_type;

endpackage

// ----- rtl/core/kps_queue.sv -----
// kps_queue: fifo of pending key transitions with due-time pop at the head
// depends on kps_pkg

module kps_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  kps_pkg::key_cmd_type         cmd,
   input  logic [kps_pkg::TIME_BITS-1:0] due_time,
   input  logic [kps_pkg::TIME_BITS-1:0] tick_count,
   output kps_pkg::evt_type             key_event,
   output logic                         overflow
);
   import kps_pkg::*;

   logic [TIME_BITS-1:0] due_mem [QUEUE_DEPTH];
   logic                 on_mem  [QUEUE_DEPTH];

   logic [QIDX_BITS-1:0] head_ff, head_in;
   logic [QCNT_BITS-1:0] fill_ff, fill_in;

   logic                 full, do_push, do_pop, have_head;
   logic [QCNT_BITS:0]   tail_sum, head_sum;
   logic [QIDX_BITS-1:0] tail;
   logic [TIME_BITS-1:0] head_due;
   logic                 head_on;

   assign full    = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign do_push = step && cmd.hit && !full;
   assign overflow = step && cmd.hit && full;

   assign tail_sum = (QCNT_BITS+1)'(head_ff) + (QCNT_BITS+1)'(fill_ff);
   assign tail = (tail_sum >= (QCNT_BITS+1)'(QUEUE_DEPTH)) ?
                 QIDX_BITS'(tail_sum - (QCNT_BITS+1)'(QUEUE_DEPTH)) :
                 QIDX_BITS'(tail_sum);

   // an empty queue forwards the word just pushed
   always_comb begin
      if (fill_ff == '0) begin
         have_head = do_push;
         head_due  = due_time;
         head_on   = cmd.is_on;
      end else begin
         have_head = 1'b1;
         head_due  = due_mem[head_ff];
         head_on   = on_mem[head_ff];
      end
   end

   assign do_pop = step && have_head && (head_due == tick_count);
   assign key_event = !do_pop ? EV_NONE : (head_on ? EV_ON : EV_OFF);

   assign head_sum = (QCNT_BITS+1)'(head_ff) + (QCNT_BITS+1)'(1);
   always_comb begin
      head_in = head_ff;
      if (do_pop) begin
         head_in = (head_sum >= (QCNT_BITS+1)'(QUEUE_DEPTH)) ? '0 : QIDX_BITS'(head_sum);
      end
      fill_in = fill_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         due_mem[tail] <= due_time;
         on_mem[tail]  <= cmd.is_on;
      end
   end

endmodule

// ----- rtl/core/kps_ptt.sv -----
// kps_ptt: ptt state, key state and hang counter
// depends on kps_pkg

module kps_ptt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  kps_pkg::key_cmd_type        cmd,
   input  logic [kps_pkg::HANG_W-1:0]  hang_samples,
   input  logic [kps_pkg::DELAY_W-1:0] delay_samples,
   output kps_pkg::evt_type            ptt_event
);
   import kps_pkg::*;

   logic             ptt_ff, ptt_in;
   logic             key_ff, key_in;
   logic [CNT_W-1:0] hang_ff, hang_in;
   evt_type          ev;

   always_comb begin
      ptt_in  = ptt_ff;
      key_in  = key_ff;
      hang_in = hang_ff;
      ev      = EV_NONE;
      if (cmd.hit) begin
         if (cmd.is_on) begin
            if (!ptt_in) begin
               ptt_in = 1'b1;
               ev     = EV_ON;
            end
            key_in = 1'b1;
         end else begin
            key_in  = 1'b0;
            hang_in = CNT_W'(hang_samples) + CNT_W'(delay_samples);
         end
      end
      // hang countdown, saturating at zero
      if (!key_in && ptt_in) begin
         if (hang_in != '0) begin
            hang_in = hang_in - CNT_W'(1);
         end
         if (hang_in == '0) begin
            ptt_in = 1'b0;
            ev     = EV_OFF;
         end
      end
   end

   assign ptt_event = step ? ev : EV_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptt_ff  <= 1'b0;
         key_ff  <= 1'b0;
         hang_ff <= '0;
      end else if (step) begin
         ptt_ff  <= ptt_in;
         key_ff  <= key_in;
         hang_ff <= hang_in;
      end
   end

endmodule

// ----- rtl/core/key_ptt_sequencer.sv -----
// key_ptt_sequencer: top level of the key / ptt sequencer
// depends on kps_pkg, kps_queue and kps_ptt
//
//   channel   dir  handshake         payload
//   req_      in   tvalid / tready   tdata: status, note; tuser: event valid
//   rsp_      out  tvalid / tready   tdata: key event, ptt event, overflow
//   csr_      in   wr_en             addr, wr_data (no read-back)
//
// one word in, one word out; a new word is taken every cycle while
// rsp_tready is high; the path runs through the input register, then
// the result register, with decode, queue head compare and hang count
// all settling between them
// synchronous active-high reset clears control state, loads csr defaults
// a stalled result holds in the output register; the input register still
// takes one more word, after which req_tready follows rsp_tready

module key_ptt_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] status_byte, [14:8] note_number, [15] zero
   input  logic        req_tuser,   // [0] event_valid
   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] key_event, [3:2] ptt_event,
                                    // [4] queue_overflow, [7:5] zero
   // register writes
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [kps_pkg::CSR_W-1:0] csr_wr_data
);
   import kps_pkg::*;

   // configuration registers
   logic [CHAN_W-1:0]  chan_ff;
   logic [NOTE_W-1:0]  note_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [HANG_W-1:0]  hang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= CHAN_W'(1);
         note_ff  <= '0;
         delay_ff <= '0;
         hang_ff  <= HANG_W'(48000);
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_addr))
            REG_MIDI_CHANNEL:  chan_ff  <= csr_wr_data[CHAN_W-1:0];
            REG_KEY_NOTE:      note_ff  <= csr_wr_data[NOTE_W-1:0];
            REG_DELAY_SAMPLES: delay_ff <= csr_wr_data[DELAY_W-1:0];
            REG_HANG_SAMPLES:  hang_ff  <= csr_wr_data[HANG_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic              in_vld_ff, in_vld_in;
   logic              ev_vld_ff;
   logic [7:0]        status_ff;
   logic [NOTE_W-1:0] inote_ff;

   // output register
   logic              out_vld_ff, out_vld_in;
   logic [7:0]        out_data_ff;

   logic step;   // the held word is processed and its result registered

   assign step       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || step;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (step) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (step) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ev_vld_ff <= req_tuser;
         status_ff <= req_tdata[7:0];
         inote_ff  <= req_tdata[14:8];
      end
   end

   // midi decode: channel is low nibble plus one, command is high nibble
   logic [CHAN_W-1:0] ev_chan;
   logic [7:0]        ev_cmd;
   key_cmd_type       cmd;

   assign ev_chan   = CHAN_W'(status_ff[3:0] & CHAN_MASK) + CHAN_W'(1);
   assign ev_cmd    = status_ff & CMD_MASK;
   assign cmd.hit   = ev_vld_ff && (ev_chan == chan_ff) && (inote_ff == note_ff) &&
                      ((ev_cmd == CMD_ON) || (ev_cmd == CMD_OFF));
   assign cmd.is_on = (ev_cmd == CMD_ON);

   // sample tick counter, wraps at its width
   logic [TIME_BITS-1:0] tick_ff;
   logic [TIME_BITS-1:0] due_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (step) begin
         tick_ff <= tick_ff + TIME_BITS'(1);
      end
   end

   // due time taken modulo the counter width
   assign due_time = TIME_BITS'(33'(tick_ff) + 33'(delay_ff));

   evt_type key_event, ptt_event;
   logic    overflow;

   kps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (cmd),
      .due_time   (due_time),
      .tick_count (tick_ff),
      .key_event  (key_event),
      .overflow   (overflow)
   );

   kps_ptt u_ptt (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .cmd           (cmd),
      .hang_samples  (hang_ff),
      .delay_samples (delay_ff),
      .ptt_event     (ptt_event)
   );

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= {3'b000, overflow, ptt_event, key_event};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
